// ----- src/pso_pkg.sv -----
// Shared types and constants for the particle swarm element update block.
// Holds the configuration register map, reset values and datapath widths.
package pso_pkg;

  localparam int POS_W  = 24;
  localparam int RAND_W = 17;
  localparam int ITER_W = 16;
  localparam int ACC_W  = 20;
  localparam int WGT_W  = 17;
  localparam int SPAN_W = 16;
  localparam int LIM_W  = 23;

  localparam int NUM_W  = ITER_W + WGT_W;
  localparam int Q_W    = WGT_W;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_ACCEL_PERSONAL = 3'd0;
  localparam logic [2:0] REG_ACCEL_GLOBAL   = 3'd1;
  localparam logic [2:0] REG_WEIGHT_START   = 3'd2;
  localparam logic [2:0] REG_WEIGHT_END     = 3'd3;
  localparam logic [2:0] REG_WEIGHT_SPAN    = 3'd4;
  localparam logic [2:0] REG_VEL_LIMIT      = 3'd5;
  localparam logic [2:0] REG_POS_MIN        = 3'd6;
  localparam logic [2:0] REG_POS_MAX        = 3'd7;

  localparam logic [ACC_W-1:0]  RST_ACCEL_PERSONAL = 20'd131072;
  localparam logic [ACC_W-1:0]  RST_ACCEL_GLOBAL   = 20'd131072;
  localparam logic [WGT_W-1:0]  RST_WEIGHT_START   = 17'd58982;
  localparam logic [WGT_W-1:0]  RST_WEIGHT_END     = 17'd26214;
  localparam logic [SPAN_W-1:0] RST_WEIGHT_SPAN    = 16'd5000;
  localparam logic [LIM_W-1:0]  RST_VEL_LIMIT      = 23'd655360;
  localparam logic [LIM_W-1:0]  RST_POS_MIN        = 23'd6554;
  localparam logic [LIM_W-1:0]  RST_POS_MAX        = 23'd6553600;

  typedef struct packed {
    logic [ACC_W-1:0]  accel_personal;
    logic [ACC_W-1:0]  accel_global;
    logic [WGT_W-1:0]  weight_start;
    logic [WGT_W-1:0]  weight_end;
    logic [SPAN_W-1:0] weight_span;
    logic [LIM_W-1:0]  vel_limit;
    logic [LIM_W-1:0]  pos_min;
    logic [LIM_W-1:0]  pos_max;
  } cfg_t;

endpackage

// ----- src/pso_cfg.sv -----
// APB-style configuration register file for the particle swarm update.
// Depends on pso_pkg for the register map, reset values and cfg_t.
module pso_cfg
  import pso_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_personal <= RST_ACCEL_PERSONAL;
      cfg_r.accel_global   <= RST_ACCEL_GLOBAL;
      cfg_r.weight_start   <= RST_WEIGHT_START;
      cfg_r.weight_end     <= RST_WEIGHT_END;
      cfg_r.weight_span    <= RST_WEIGHT_SPAN;
      cfg_r.vel_limit      <= RST_VEL_LIMIT;
      cfg_r.pos_min        <= RST_POS_MIN;
      cfg_r.pos_max        <= RST_POS_MAX;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACCEL_PERSONAL: cfg_r.accel_personal <= pwdata[ACC_W-1:0];
        REG_ACCEL_GLOBAL:   cfg_r.accel_global   <= pwdata[ACC_W-1:0];
        REG_WEIGHT_START:   cfg_r.weight_start   <= pwdata[WGT_W-1:0];
        REG_WEIGHT_END:     cfg_r.weight_end     <= pwdata[WGT_W-1:0];
        REG_WEIGHT_SPAN:    cfg_r.weight_span    <= pwdata[SPAN_W-1:0];
        REG_VEL_LIMIT:      cfg_r.vel_limit      <= pwdata[LIM_W-1:0];
        REG_POS_MIN:        cfg_r.pos_min        <= pwdata[LIM_W-1:0];
        REG_POS_MAX:        cfg_r.pos_max        <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACCEL_PERSONAL: prdata = DATA_W'(cfg_r.accel_personal);
      REG_ACCEL_GLOBAL:   prdata = DATA_W'(cfg_r.accel_global);
      REG_WEIGHT_START:   prdata = DATA_W'(cfg_r.weight_start);
      REG_WEIGHT_END:     prdata = DATA_W'(cfg_r.weight_end);
      REG_WEIGHT_SPAN:    prdata = DATA_W'(cfg_r.weight_span);
      REG_VEL_LIMIT:      prdata = DATA_W'(cfg_r.vel_limit);
      REG_POS_MIN:        prdata = DATA_W'(cfg_r.pos_min);
      REG_POS_MAX:        prdata = DATA_W'(cfg_r.pos_max);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- src/pso_div.sv -----
// Pipelined restoring divider for the inertia schedule, one quotient bit per stage.
// Depends on pso_pkg for the numerator, quotient and span widths.
module pso_div
  import pso_pkg::*;
(
  input  logic              clk,
  input  logic [SPAN_W-1:0] span_i,
  input  logic [NUM_W-1:0]  num_i,
  output logic [Q_W-1:0]    q_o
);

  // The quotient is known to fit Q_W bits, so the upper numerator bits
  // already form a partial remainder below the divisor.
  logic [SPAN_W-1:0] rem_r  [Q_W];
  logic [Q_W-1:0]    bits_r [Q_W];
  logic [Q_W-1:0]    q_r    [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [SPAN_W-1:0] rem_src;
    logic [Q_W-1:0]    bits_src;
    logic [Q_W-1:0]    q_src;
    logic [SPAN_W:0]   trial;
    logic              ge;
    logic [SPAN_W:0]   diff;

    if (k == 0) begin : g_first
      assign rem_src  = num_i[NUM_W-1:Q_W];
      assign bits_src = num_i[Q_W-1:0];
      assign q_src    = '0;
    end else begin : g_next
      assign rem_src  = rem_r[k-1];
      assign bits_src = bits_r[k-1];
      assign q_src    = q_r[k-1];
    end

    assign trial = {rem_src, bits_src[Q_W-1]};
    assign ge    = trial >= {1'b0, span_i};
    assign diff  = trial - {1'b0, span_i};

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      bits_r[k] <= {bits_src[Q_W-2:0], 1'b0};
      q_r[k]    <= {q_src[Q_W-2:0], ge};
    end
  end

  assign q_o = q_r[Q_W-1];

endmodule

// ----- src/pso_delay.sv -----
// Delay line that carries a payload word and its valid bit through a fixed
// number of register stages. No package dependencies.
module pso_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [W-1:0] data_i,
  output logic         vld_o,
  output logic [W-1:0] data_o
);

  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     data_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    data_r[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) begin
      data_r[i] <= data_r[i-1];
    end
  end

  assign vld_o  = vld_r[DEPTH-1];
  assign data_o = data_r[DEPTH-1];

endmodule

// ----- src/pso_particle_element_update.sv -----
// Particle swarm element update: one dimension of one particle per transaction.
// The result strobe is registered after the capture, schedule, attraction, divider/delay,
// weight, inertia, sum, clamp and position stages; the 17-stage weight divider is most of it.
// A new transaction is taken every cycle and busy stays low, since the receiver never
// stalls. Synchronous active-low reset clears all valid bits and loads register defaults.
module pso_particle_element_update
  import pso_pkg::*;
#(
  parameter int BOUNCE_OFFSET = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  in_position,
  input  logic signed [POS_W-1:0]  in_velocity,
  input  logic signed [POS_W-1:0]  in_personal_best,
  input  logic signed [POS_W-1:0]  in_global_best,
  input  logic        [RAND_W-1:0] in_rand_personal,
  input  logic        [RAND_W-1:0] in_rand_global,
  input  logic        [ITER_W-1:0] in_iteration,
  output logic                     out_strobe,
  output logic signed [POS_W-1:0]  out_new_position,
  output logic signed [POS_W-1:0]  out_new_velocity,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int PROD_W = ACC_W + 2 + POS_W + 1;
  localparam int TERM_W = PROD_W - 16;
  localparam int WV_W   = WGT_W + 1 + POS_W;
  localparam int SUM_W  = TERM_W + 2;
  localparam logic signed [POS_W:0] BOUNCE_V = (POS_W + 1)'(BOUNCE_OFFSET);
  localparam logic signed [POS_W:0] POS_HI   = {2'b00, {(POS_W - 1){1'b1}}};

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  v;
    logic signed [TERM_W-1:0] t1;
    logic signed [TERM_W-1:0] t2;
    logic                     over;
    logic                     zspan;
    logic                     neg;
  } pipe_t;

  cfg_t cfg;

  pso_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy = 1'b0;

  // Stage 1: input capture.
  logic                     s1_vld_r;
  logic signed [POS_W-1:0]  s1_x_r, s1_v_r, s1_pb_r, s1_gb_r;
  logic        [RAND_W-1:0] s1_r1_r, s1_r2_r;
  logic        [ITER_W-1:0] s1_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r  <= in_position;
    s1_v_r  <= in_velocity;
    s1_pb_r <= in_personal_best;
    s1_gb_r <= in_global_best;
    s1_r1_r <= in_rand_personal;
    s1_r2_r <= in_rand_global;
    s1_it_r <= in_iteration;
  end

  // Stage 2: schedule numerator, acceleration coefficients, best distances.
  logic signed [WGT_W:0]        wdiff;
  logic                         wneg;
  logic        [WGT_W-1:0]      wmag;
  logic                         s2_vld_r;
  logic        [NUM_W-1:0]      s2_num_r;
  logic        [ACC_W+RAND_W-1:0] s2_k1_r, s2_k2_r;
  logic signed [POS_W:0]        s2_d1_r, s2_d2_r;
  logic signed [POS_W-1:0]      s2_x_r, s2_v_r;
  logic                         s2_over_r, s2_zspan_r, s2_neg_r;
  logic        [WGT_W:0]        wdiff_abs;

  assign wdiff     = $signed({1'b0, cfg.weight_start}) - $signed({1'b0, cfg.weight_end});
  assign wneg      = wdiff[WGT_W];
  assign wdiff_abs = wneg ? -wdiff : wdiff;
  assign wmag      = wdiff_abs[WGT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_num_r   <= NUM_W'(s1_it_r) * NUM_W'(wmag);
    s2_k1_r    <= (ACC_W + RAND_W)'(cfg.accel_personal) * (ACC_W + RAND_W)'(s1_r1_r);
    s2_k2_r    <= (ACC_W + RAND_W)'(cfg.accel_global) * (ACC_W + RAND_W)'(s1_r2_r);
    s2_d1_r    <= {s1_pb_r[POS_W-1], s1_pb_r} - {s1_x_r[POS_W-1], s1_x_r};
    s2_d2_r    <= {s1_gb_r[POS_W-1], s1_gb_r} - {s1_x_r[POS_W-1], s1_x_r};
    s2_x_r     <= s1_x_r;
    s2_v_r     <= s1_v_r;
    s2_over_r  <= s1_it_r > cfg.weight_span;
    s2_zspan_r <= cfg.weight_span == '0;
    s2_neg_r   <= wneg;
  end

  // Stage 3: attraction terms, feeding the delay line; the divider runs from the stage 2 numerator.
  logic        [ACC_W+RAND_W-17:0] k1, k2;
  logic signed [PROD_W-1:0]        prod1, prod2;
  logic                            s3_vld_r;
  pipe_t                           s3_r;

  assign k1 = s2_k1_r[ACC_W+RAND_W-1:16];
  assign k2 = s2_k2_r[ACC_W+RAND_W-1:16];
  assign prod1 = $signed({{(PROD_W - ACC_W - 1){1'b0}}, k1}) *
                 $signed({{(PROD_W - POS_W - 1){s2_d1_r[POS_W]}}, s2_d1_r});
  assign prod2 = $signed({{(PROD_W - ACC_W - 1){1'b0}}, k2}) *
                 $signed({{(PROD_W - POS_W - 1){s2_d2_r[POS_W]}}, s2_d2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r.x     <= s2_x_r;
    s3_r.v     <= s2_v_r;
    s3_r.t1    <= prod1[PROD_W-1:16];
    s3_r.t2    <= prod2[PROD_W-1:16];
    s3_r.over  <= s2_over_r;
    s3_r.zspan <= s2_zspan_r;
    s3_r.neg   <= s2_neg_r;
  end

  logic [Q_W-1:0] div_q;

  pso_div u_div (
    .clk    (clk),
    .span_i (cfg.weight_span),
    .num_i  (s2_num_r),
    .q_o    (div_q)
  );

  logic  dl_vld;
  pipe_t dl_data;

  pso_delay #(
    .W     ($bits(pipe_t)),
    .DEPTH (Q_W - 1)
  ) u_delay (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s3_vld_r),
    .data_i (s3_r),
    .vld_o  (dl_vld),
    .data_o (dl_data)
  );

  // Weight selection.
  logic                     w_vld_r;
  logic        [WGT_W-1:0]  w_r, w_nxt;
  logic signed [POS_W-1:0]  w_x_r, w_v_r;
  logic signed [TERM_W-1:0] w_t1_r, w_t2_r;

  always_comb begin
    priority if (dl_data.over) begin
      w_nxt = cfg.weight_end;
    end else if (dl_data.zspan) begin
      w_nxt = cfg.weight_start;
    end else if (dl_data.neg) begin
      w_nxt = cfg.weight_start + div_q;
    end else begin
      w_nxt = cfg.weight_start - div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= 1'b0;
    end else begin
      w_vld_r <= dl_vld;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    w_x_r  <= dl_data.x;
    w_v_r  <= dl_data.v;
    w_t1_r <= dl_data.t1;
    w_t2_r <= dl_data.t2;
  end

  // Inertia product and attraction sum.
  logic                      m_vld_r;
  logic signed [WV_W-1:0]    m_wv_r;
  logic signed [TERM_W:0]    m_t12_r;
  logic signed [POS_W-1:0]   m_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= w_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m_wv_r  <= $signed({{(WV_W - WGT_W){1'b0}}, w_r}) *
               $signed({{(WV_W - POS_W){w_v_r[POS_W-1]}}, w_v_r});
    m_t12_r <= {w_t1_r[TERM_W-1], w_t1_r} + {w_t2_r[TERM_W-1], w_t2_r};
    m_x_r   <= w_x_r;
  end

  // Full-width velocity sum.
  logic                    a_vld_r;
  logic signed [SUM_W-1:0] a_nv_r;
  logic signed [POS_W-1:0] a_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_nv_r <= {{(SUM_W - WV_W + 16){m_wv_r[WV_W-1]}}, m_wv_r[WV_W-1:16]} +
              {m_t12_r[TERM_W], m_t12_r};
    a_x_r  <= m_x_r;
  end

  // Velocity clamp.
  logic                    c_vld_r;
  logic signed [POS_W-1:0] c_nv_r, c_nv_nxt;
  logic signed [POS_W-1:0] c_x_r;
  logic signed [SUM_W-1:0] lim_p, lim_n;

  assign lim_p = $signed({{(SUM_W - LIM_W){1'b0}}, cfg.vel_limit});
  assign lim_n = -lim_p;

  always_comb begin
    priority if (a_nv_r > lim_p) begin
      c_nv_nxt = lim_p[POS_W-1:0];
    end else if (a_nv_r < lim_n) begin
      c_nv_nxt = lim_n[POS_W-1:0];
    end else begin
      c_nv_nxt = a_nv_r[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_nv_r <= c_nv_nxt;
    c_x_r  <= a_x_r;
  end

  // Position update with bounce at the bounds.
  logic signed [POS_W:0]   np, hi, lo, np_b;
  logic signed [POS_W-1:0] pos_nxt;
  logic                    out_strobe_r;
  logic signed [POS_W-1:0] out_pos_r, out_vel_r;

  assign np = {c_x_r[POS_W-1], c_x_r} + {c_nv_r[POS_W-1], c_nv_r};
  assign hi = $signed({2'b00, cfg.pos_max});
  assign lo = $signed({2'b00, cfg.pos_min});

  always_comb begin
    priority if (np > hi) begin
      np_b = hi - BOUNCE_V;
    end else if (np < lo) begin
      np_b = lo + BOUNCE_V;
    end else begin
      np_b = np;
    end
    pos_nxt = (np_b > POS_HI) ? POS_HI[POS_W-1:0] : np_b[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r <= pos_nxt;
    out_vel_r <= c_nv_r;
  end

  assign out_strobe       = out_strobe_r;
  assign out_new_position = out_pos_r;
  assign out_new_velocity = out_vel_r;

endmodule
